// ----- rtl/core/gbat_pkg.sv -----
// Shared types and constants of the glyph bitmap to alpha texture block.
package gbat_pkg;

    localparam int CMD_W      = 1;
    localparam int ADDR_W     = 13;
    localparam int BYTE_W     = 8;
    localparam int COORD_W    = 8;
    localparam int ARGB_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;
    localparam int POS_W      = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

    localparam logic [23:0] COLOR_WHITE = 24'hff_ffff;
    localparam logic [7:0]  ALPHA_FULL  = 8'd255;

    typedef enum logic [1:0] {
        GM_MONO = 2'd0,
        GM_L4   = 2'd1,
        GM_L16  = 2'd2,
        GM_L64  = 2'd3
    } t_gray_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAY_MODE   = 4'd0,
        CFG_BOX_WIDTH   = 4'd1,
        CFG_BOX_HEIGHT  = 4'd2,
        CFG_ORIGIN_X    = 4'd3,
        CFG_TOP_OFFSET  = 4'd4,
        CFG_CELL_WIDTH  = 4'd5,
        CFG_CELL_HEIGHT = 4'd6,
        CFG_GLYPH_SIZE  = 4'd7
    } t_cfg_idx;

endpackage

// ----- rtl/core/gbat_ifs.sv -----
// Channel interfaces of the glyph bitmap to alpha texture block.
interface gbat_req_if;
    import gbat_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  byte_addr;
    logic [BYTE_W-1:0]  byte_value;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    modport source (output valid, cmd, byte_addr, byte_value, pixel_x, pixel_y, input ready);
    modport sink (input valid, cmd, byte_addr, byte_value, pixel_x, pixel_y, output ready);
endinterface

interface gbat_rsp_if;
    import gbat_pkg::*;
    logic              valid;
    logic              ready;
    logic [ARGB_W-1:0] pixel_argb;
    logic              covered;
    modport source (output valid, pixel_argb, covered, input ready);
    modport sink (input valid, pixel_argb, covered, output ready);
endinterface

interface gbat_cfg_if;
    import gbat_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gbat_ram.sv -----
// Single-port synchronous RAM with a registered read.
module gbat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/glyph_bitmap_to_alpha_texture.sv -----
// Top level of the glyph bitmap to alpha texture block.
// The request channel carries transactions of two kinds: a load writes one
// glyph byte into the glyph store, and a read asks for one texture pixel.
// Each read returns exactly one transaction on the response channel, with
// the ARGB pixel and a covered flag; a load returns nothing. Requests are
// handled in order, so a read sees every load accepted before it.
// Registers are written through the configuration channel, which is always
// ready; the user must write them only while no request is in flight, as
// the block does not enforce this. A read passes the coverage test, which is
// registered into stage A at the accepting edge, the address multiply into
// stage B, the glyph store read into stage C and the alpha into the output
// register. The pipeline takes one transaction per cycle while the receiver
// does not stall; the single port of the glyph store does one load or one
// read per cycle. When the receiver stalls, the output register holds its
// transaction and the whole pipeline stops; the request channel is not ready
// until the response is taken. Reset clears the pipeline and the registers;
// the glyph store is not cleared and must be loaded before it is read.
module glyph_bitmap_to_alpha_texture #(
    parameter int GLYPH_BYTES = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbat_cfg_if.sink   i_cfg,
    gbat_req_if.sink   i_req,
    gbat_rsp_if.source o_rsp
);
    import gbat_pkg::*;

    localparam int AW = $clog2(GLYPH_BYTES);

    t_gray_mode  r_gray_mode;
    logic [7:0]  r_box_width;
    logic [7:0]  r_box_height;
    logic [7:0]  r_origin_x;
    logic [8:0]  r_top_offset;
    logic [7:0]  r_cell_width;
    logic [7:0]  r_cell_height;
    logic [13:0] r_glyph_size;

    logic [8:0]  r_mul;
    logic        r_half;

    logic        w_en;

    logic              r_a_valid;
    logic [CMD_W-1:0]  r_a_cmd;
    logic              r_a_cov;
    logic [7:0]        r_a_row;
    logic [7:0]        r_a_sx;
    logic [ADDR_W-1:0] r_a_addr;
    logic [BYTE_W-1:0] r_a_data;

    logic              r_b_valid;
    logic [CMD_W-1:0]  r_b_cmd;
    logic              r_b_cov;
    logic [POS_W-1:0]  r_b_pos;
    logic [2:0]        r_b_bit;
    logic [BYTE_W-1:0] r_b_data;

    logic             r_c_valid;
    logic [CMD_W-1:0] r_c_cmd;
    logic             r_c_cov;
    logic             r_c_ok;
    logic [2:0]       r_c_bit;

    logic              r_out_valid;
    logic [ARGB_W-1:0] r_out_argb;
    logic              r_out_cov;

    logic [7:0]  w_ox;
    logic [7:0]  w_shift;
    logic [9:0]  w_x;
    logic [10:0] w_y;
    logic [9:0]  w_sx;
    logic        w_cov;

    logic [5:0]  w_stride;
    logic [8:0]  w_pitch;
    logic [13:0] w_total;

    logic [7:0]       w_rowm;
    logic [7:0]       w_col;
    logic [POS_W-1:0] w_pos;

    logic        w_in_store;
    logic        w_in_glyph;
    logic        w_ram_en;
    logic        w_ram_we;
    logic [7:0]  w_rdata;

    logic [15:0] w_prod;
    logic [15:0] w_level;
    logic [7:0]  w_alpha;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode   <= GM_MONO;
            r_box_width   <= '0;
            r_box_height  <= '0;
            r_origin_x    <= '0;
            r_top_offset  <= '0;
            r_cell_width  <= 8'd1;
            r_cell_height <= 8'd1;
            r_glyph_size  <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_GRAY_MODE:   r_gray_mode   <= t_gray_mode'(i_cfg.data[1:0]);
                CFG_BOX_WIDTH:   r_box_width   <= i_cfg.data[7:0];
                CFG_BOX_HEIGHT:  r_box_height  <= i_cfg.data[7:0];
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg.data[7:0];
                CFG_TOP_OFFSET:  r_top_offset  <= i_cfg.data[8:0];
                CFG_CELL_WIDTH:  r_cell_width  <= i_cfg.data[7:0];
                CFG_CELL_HEIGHT: r_cell_height <= i_cfg.data[7:0];
                CFG_GLYPH_SIZE:  r_glyph_size  <= i_cfg.data[13:0];
                default: begin
                end
            endcase
        end
    end

    // Row pitch and the half-height test depend on the registers only.
    assign w_stride = 6'(({3'b0, r_box_width[7:5]} + 6'd1) << 2);
    assign w_pitch  = ({1'b0, r_box_width} + 9'd3) & ~9'd3;
    assign w_total  = 14'(r_box_height * w_stride);

    always_ff @(posedge i_clk) begin
        r_mul  <= (r_gray_mode == GM_MONO) ? {3'b0, w_stride} : w_pitch;
        r_half <= ({1'b0, w_total[13:1]} == r_glyph_size);
    end

    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    // Stage A: map the texture pixel onto the black box.
    assign w_ox    = r_origin_x[7] ? 8'd0 : r_origin_x;
    assign w_shift = r_origin_x[7] ? 8'(-r_origin_x) : 8'd0;
    assign w_x     = {2'b0, i_req.pixel_x} - {2'b0, w_ox};
    assign w_y     = {3'b0, i_req.pixel_y} - {{2{r_top_offset[8]}}, r_top_offset};
    assign w_sx    = {1'b0, w_x[8:0]} + {2'b0, w_shift};
    assign w_cov   = (i_req.pixel_x < r_cell_width) && (i_req.pixel_y < r_cell_height)
                  && (r_glyph_size != 14'd0)
                  && !w_x[9] && (w_x[8:0] < {1'b0, r_box_width})
                  && !w_y[10] && (w_y[9:0] < {2'b0, r_box_height})
                  && (w_sx < {2'b0, r_box_width});

    // Stage B: byte position in the glyph store.
    assign w_rowm = ((r_gray_mode == GM_MONO) && r_half) ? {1'b0, r_a_row[7:1]} : r_a_row;
    assign w_col  = (r_gray_mode == GM_MONO) ? {3'b0, r_a_sx[7:3]} : r_a_sx;
    assign w_pos  = (r_a_cmd == CMD_READ) ? POS_W'(w_rowm * r_mul) + {8'b0, w_col}
                                          : POS_W'(r_a_addr);

    // Stage C: one glyph store access, a load or a read, in request order.
    assign w_in_store = ({1'b0, r_b_pos} < 17'(GLYPH_BYTES));
    assign w_in_glyph = (r_b_pos < {2'b0, r_glyph_size});
    assign w_ram_we   = (r_b_cmd == CMD_LOAD);
    assign w_ram_en   = w_en && r_b_valid && w_in_store
                     && (w_ram_we || (r_b_cov && w_in_glyph));

    gbat_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (GLYPH_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (r_b_pos[AW-1:0]),
        .i_wdata (r_b_data),
        .o_rdata (w_rdata)
    );

    // Stage D: alpha from the fetched byte.
    assign w_prod = ({w_rdata, 8'b0}) - {8'b0, w_rdata};

    always_comb begin
        w_level = '0;
        case (r_gray_mode)
            GM_MONO: w_level = w_rdata[3'd7 - r_c_bit] ? {8'b0, ALPHA_FULL} : 16'd0;
            GM_L4:   w_level = w_prod >> 2;
            GM_L16:  w_level = w_prod >> 4;
            GM_L64:  w_level = w_prod >> 6;
            default: w_level = '0;
        endcase
        if (!r_c_ok) begin
            w_alpha = 8'd0;
        end else if (w_level > {8'b0, ALPHA_FULL}) begin
            w_alpha = ALPHA_FULL;
        end else begin
            w_alpha = w_level[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= i_req.valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid && (r_c_cmd == CMD_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_cmd  <= i_req.cmd;
            r_a_cov  <= w_cov;
            r_a_row  <= w_y[7:0];
            r_a_sx   <= w_sx[7:0];
            r_a_addr <= i_req.byte_addr;
            r_a_data <= i_req.byte_value;

            r_b_cmd  <= r_a_cmd;
            r_b_cov  <= r_a_cov;
            r_b_pos  <= w_pos;
            r_b_bit  <= r_a_sx[2:0];
            r_b_data <= r_a_data;

            r_c_cmd  <= r_b_cmd;
            r_c_cov  <= r_b_cov;
            r_c_ok   <= r_b_cov && w_in_store && w_in_glyph;
            r_c_bit  <= r_b_bit;

            r_out_cov  <= r_c_cov;
            r_out_argb <= r_c_cov ? {w_alpha, COLOR_WHITE} : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.pixel_argb = r_out_argb;
    assign o_rsp.covered    = r_out_cov;

    a_rsp_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_c_valid && (r_c_cmd == CMD_READ)))
        else $error("Response without a read in the store stage.");

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.covered) |-> (o_rsp.pixel_argb == '0))
        else $error("Uncovered pixel with a nonzero value.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> ($stable(r_c_valid) && $stable(r_b_valid)))
        else $error("Pipeline moved during a response stall.");

endmodule
